>>> hw/rtl/etl_pkg.sv
`default_nettype none

package etl_pkg;

    // token kinds as seen on the result port
    typedef enum logic [4:0] {
        KIND_IDENT  = 5'd0,
        KIND_INT    = 5'd1,
        KIND_ASSIGN = 5'd2,
        KIND_ADD    = 5'd3,
        KIND_SUB    = 5'd4,
        KIND_MUL    = 5'd5,
        KIND_DIV    = 5'd6,
        KIND_EQ     = 5'd7,
        KIND_NEQ    = 5'd8,
        KIND_LT     = 5'd9,
        KIND_LE     = 5'd10,
        KIND_GT     = 5'd11,
        KIND_GE     = 5'd12,
        KIND_AND    = 5'd13,
        KIND_OR     = 5'd14,
        KIND_LPAREN = 5'd15,
        KIND_RPAREN = 5'd16,
        KIND_EOL    = 5'd17,
        KIND_ERR    = 5'd18
    } kind_t;

    // what the lexer is holding between bytes
    typedef enum logic [3:0] {
        PEND_NONE  = 4'd0,
        PEND_IDENT = 4'd1,
        PEND_INT   = 4'd2,
        PEND_EQ    = 4'd3,
        PEND_BANG  = 4'd4,
        PEND_LT    = 4'd5,
        PEND_GT    = 4'd6,
        PEND_AMP   = 4'd7,
        PEND_BAR   = 4'd8
    } pend_t;

    localparam int          POS_W   = 12;
    localparam int          LEN_W   = 12;
    localparam logic [11:0] LEN_CAP = 12'd4095;
    localparam int          SLOTS   = 3;

    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        kind_t             kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic              last;
    } token_t;

    // all results caused by one byte, in order: flushed, middle, end of line
    typedef struct packed {
        logic [SLOTS-1:0]  valid;
        token_t [SLOTS-1:0] tok;
    } bundle_t;

    typedef struct packed {
        logic discarding;
        logic pend_idle;
    } front_status_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic kind_t single_kind(input pend_t held);
        kind_t k;
        unique case (held)
            PEND_EQ: k = KIND_ASSIGN;
            PEND_LT: k = KIND_LT;
            PEND_GT: k = KIND_GT;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

    function automatic kind_t pair_kind(input pend_t held, input logic [7:0] c);
        kind_t k;
        k = KIND_ERR;
        unique case (held)
            PEND_EQ:   if (c == CH_EQ)  k = KIND_EQ;
            PEND_BANG: if (c == CH_EQ)  k = KIND_NEQ;
            PEND_LT:   if (c == CH_EQ)  k = KIND_LE;
            PEND_GT:   if (c == CH_EQ)  k = KIND_GE;
            PEND_AMP:  if (c == CH_AMP) k = KIND_AND;
            PEND_BAR:  if (c == CH_BAR) k = KIND_OR;
            default:   k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/etl_front.sv
`default_nettype none

module etl_front #(
    parameter int LINE_MAX = 4096
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire logic [7:0]             char_code,
    input  wire logic                   line_end,
    output etl_pkg::bundle_t            bundle,
    output logic                        bundle_push,
    output etl_pkg::front_status_t      status
);

    localparam int          CAP_INT = (LINE_MAX - 1 > 4095) ? 4095 : LINE_MAX - 1;
    localparam logic [11:0] POS_CAP = 12'(CAP_INT);

    etl_pkg::pend_t    pend_reg, pend_next;
    logic [11:0]       start_reg, start_next;
    logic [11:0]       len_reg, len_next;
    logic [11:0]       pos_reg, pos_next;
    logic              disc_reg, disc_next;

    logic [11:0]       adv_pos;
    logic [11:0]       len_inc;
    logic              is_word;
    logic              consumed;
    logic              a_err, b_err, c_err, any_err;
    etl_pkg::kind_t    pk, sk, ck;
    etl_pkg::pend_t    fresh_pend, mid_pend;
    logic [11:0]       mid_start, mid_len;
    etl_pkg::token_t   tok_a, tok_b, tok_c, tok_e;
    logic              a_valid, b_valid, c_valid;

    assign adv_pos = (pos_reg < POS_CAP) ? pos_reg + 12'd1 : POS_CAP;
    assign len_inc = (len_reg < etl_pkg::LEN_CAP) ? len_reg + 12'd1 : len_reg;
    assign is_word = (pend_reg == etl_pkg::PEND_IDENT) || (pend_reg == etl_pkg::PEND_INT);

    // classification and results of one byte
    always_comb
    begin
        pk       = etl_pkg::pair_kind(pend_reg, char_code);
        sk       = etl_pkg::single_kind(pend_reg);
        consumed = 1'b0;
        a_valid  = 1'b0;
        a_err    = 1'b0;
        tok_a    = '0;

        // held token meets the new byte
        if (is_word) begin
            if ((pend_reg == etl_pkg::PEND_IDENT)
                ? (etl_pkg::is_letter(char_code) || etl_pkg::is_digit(char_code))
                : etl_pkg::is_digit(char_code))
            begin
                consumed = 1'b1;
            end
            else
            begin
                a_valid     = 1'b1;
                tok_a.kind  = (pend_reg == etl_pkg::PEND_IDENT) ? etl_pkg::KIND_IDENT
                                                                : etl_pkg::KIND_INT;
                tok_a.start = start_reg;
                tok_a.len   = len_reg;
            end
        end
        else if (pend_reg != etl_pkg::PEND_NONE) begin
            a_valid     = 1'b1;
            tok_a.start = start_reg;
            if (pk != etl_pkg::KIND_ERR) begin
                consumed   = 1'b1;
                tok_a.kind = pk;
                tok_a.len  = 12'd2;
            end
            else
            begin
                a_err      = (sk == etl_pkg::KIND_ERR);
                tok_a.kind = sk;
                tok_a.len  = 12'd1;
                tok_a.last = a_err;
            end
        end

        // the byte on its own
        fresh_pend  = etl_pkg::PEND_NONE;
        b_valid     = 1'b0;
        b_err       = 1'b0;
        tok_b       = '0;
        tok_b.start = pos_reg;
        tok_b.len   = 12'd1;
        if (etl_pkg::is_space(char_code)) begin
            fresh_pend = etl_pkg::PEND_NONE;
        end
        else if (etl_pkg::is_letter(char_code)) begin
            fresh_pend = etl_pkg::PEND_IDENT;
        end
        else if (etl_pkg::is_digit(char_code)) begin
            fresh_pend = etl_pkg::PEND_INT;
        end
        else
        begin
            b_valid = 1'b1;
            unique case (char_code)
                etl_pkg::CH_EQ:     begin fresh_pend = etl_pkg::PEND_EQ;   b_valid = 1'b0; end
                etl_pkg::CH_BANG:   begin fresh_pend = etl_pkg::PEND_BANG; b_valid = 1'b0; end
                etl_pkg::CH_LT:     begin fresh_pend = etl_pkg::PEND_LT;   b_valid = 1'b0; end
                etl_pkg::CH_GT:     begin fresh_pend = etl_pkg::PEND_GT;   b_valid = 1'b0; end
                etl_pkg::CH_AMP:    begin fresh_pend = etl_pkg::PEND_AMP;  b_valid = 1'b0; end
                etl_pkg::CH_BAR:    begin fresh_pend = etl_pkg::PEND_BAR;  b_valid = 1'b0; end
                etl_pkg::CH_PLUS:   tok_b.kind = etl_pkg::KIND_ADD;
                etl_pkg::CH_MINUS:  tok_b.kind = etl_pkg::KIND_SUB;
                etl_pkg::CH_STAR:   tok_b.kind = etl_pkg::KIND_MUL;
                etl_pkg::CH_SLASH:  tok_b.kind = etl_pkg::KIND_DIV;
                etl_pkg::CH_LPAREN: tok_b.kind = etl_pkg::KIND_LPAREN;
                etl_pkg::CH_RPAREN: tok_b.kind = etl_pkg::KIND_RPAREN;
                default:
                begin
                    tok_b.kind = etl_pkg::KIND_ERR;
                    tok_b.last = 1'b1;
                    b_err      = 1'b1;
                end
            endcase
        end
        if (a_err || consumed) begin
            b_valid    = 1'b0;
            b_err      = 1'b0;
            fresh_pend = etl_pkg::PEND_NONE;
        end

        // what is held after this byte, before the line closes
        if (consumed) begin
            mid_pend  = is_word ? pend_reg : etl_pkg::PEND_NONE;
            mid_start = start_reg;
            mid_len   = is_word ? len_inc : 12'd1;
        end
        else
        begin
            mid_pend  = fresh_pend;
            mid_start = pos_reg;
            mid_len   = 12'd1;
        end

        // flush at line end
        ck          = etl_pkg::single_kind(mid_pend);
        c_valid     = 1'b0;
        c_err       = 1'b0;
        tok_c       = '0;
        tok_c.start = mid_start;
        if (line_end && !a_err && !b_err && mid_pend != etl_pkg::PEND_NONE) begin
            c_valid = 1'b1;
            if (mid_pend == etl_pkg::PEND_IDENT || mid_pend == etl_pkg::PEND_INT) begin
                tok_c.kind = (mid_pend == etl_pkg::PEND_IDENT) ? etl_pkg::KIND_IDENT
                                                               : etl_pkg::KIND_INT;
                tok_c.len  = mid_len;
            end
            else
            begin
                tok_c.kind = ck;
                tok_c.len  = 12'd1;
                tok_c.last = (ck == etl_pkg::KIND_ERR);
                c_err      = (ck == etl_pkg::KIND_ERR);
            end
        end

        any_err     = a_err || b_err || c_err;
        tok_e.kind  = etl_pkg::KIND_EOL;
        tok_e.start = line_end ? adv_pos : pos_reg;
        tok_e.len   = 12'd0;
        tok_e.last  = 1'b1;

        bundle.tok[0]   = tok_a;
        bundle.tok[1]   = b_valid ? tok_b : tok_c;
        bundle.tok[2]   = tok_e;
        bundle.valid[0] = a_valid && !disc_reg;
        bundle.valid[1] = (b_valid || c_valid) && !disc_reg;
        bundle.valid[2] = line_end && !any_err && !disc_reg;
        bundle_push     = accept && (|bundle.valid);
    end

    // next lexer state
    always_comb
    begin
        pend_next  = pend_reg;
        start_next = start_reg;
        len_next   = len_reg;
        disc_next  = disc_reg;
        pos_next   = line_end ? 12'd0 : adv_pos;
        if (disc_reg) begin
            disc_next = !line_end;
        end
        else
        begin
            pend_next  = (any_err || line_end) ? etl_pkg::PEND_NONE : mid_pend;
            start_next = line_end ? 12'd0 : mid_start;
            len_next   = line_end ? 12'd0 : mid_len;
            disc_next  = any_err && !line_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg  <= etl_pkg::PEND_NONE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            disc_reg  <= 1'b0;
        end
        else if (accept) begin
            pend_reg  <= pend_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            disc_reg  <= disc_next;
        end
    end

    assign status.discarding = disc_reg;
    assign status.pend_idle  = (pend_reg == etl_pkg::PEND_NONE);

endmodule

`default_nettype wire

>>> hw/rtl/etl_queue.sv
`default_nettype none

module etl_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    wr_en,
    input  wire etl_pkg::bundle_t        wr_data,
    input  wire logic                    rd_en,
    output etl_pkg::bundle_t             rd_data,
    output logic                         not_empty,
    output logic                         is_full,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    etl_pkg::bundle_t  mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data   = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign fill      = count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/etl_back.sv
`default_nettype none

module etl_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire etl_pkg::bundle_t head,
    input  wire logic          head_valid,
    input  wire logic          take,
    output logic               head_pop,
    output etl_pkg::token_t    tok
);

    logic [etl_pkg::SLOTS-1:0] done_reg, done_next;
    logic [etl_pkg::SLOTS-1:0] remain;
    logic [etl_pkg::SLOTS-1:0] sel;

    assign remain = head.valid & ~done_reg;

    // oldest slot not yet handed out
    always_comb
    begin
        sel[0] = remain[0];
        sel[1] = remain[1] && !remain[0];
        sel[2] = remain[2] && !(|remain[1:0]);
        if (sel[0]) begin
            tok = head.tok[0];
        end
        else if (sel[1]) begin
            tok = head.tok[1];
        end
        else
        begin
            tok = head.tok[2];
        end
    end

    always_comb
    begin
        head_pop  = 1'b0;
        done_next = done_reg;
        if (take && head_valid) begin
            if ((remain & ~sel) == '0) begin
                head_pop  = 1'b1;
                done_next = '0;
            end
            else
            begin
                done_next = done_reg | sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/expression_token_lexer.sv
// result ports show the queue head; throughput: one byte per cycle while not full;
//   a byte gives zero to three tokens, and the result side hands out one token
//   per cycle while popped, so the bundle queue of QUEUE_DEPTH entries sets how
//   long bytes keep flowing while results back up
// reset: rst_n clears the lexer state (line position, held token, drop mode) and
//   empties the queue at once
`default_nettype none

module expression_token_lexer #(
    parameter int LINE_MAX    = 4096,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // byte side
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   char_code,
    input  wire logic         line_end,
    // token side
    output logic              empty,
    input  wire logic         pop,
    output logic [4:0]        token_kind,
    output logic [11:0]       start_pos,
    output logic [11:0]       token_len,
    output logic              last_of_line
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                    in_take;
    logic                    out_take;
    etl_pkg::bundle_t        front_bundle;
    logic                    front_push;
    etl_pkg::front_status_t  front_stat;
    etl_pkg::bundle_t        head_bundle;
    logic                    head_valid;
    logic                    head_pop;
    logic [CW-1:0]           q_fill;
    etl_pkg::token_t         out_tok;

    // a byte transaction completes whenever the queue has room, so the front
    // never waits on the result side except through the queue
    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // front: holds the partial token and turns each byte into a bundle of tokens
    etl_front #(
        .LINE_MAX (LINE_MAX)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_take),
        .char_code   (char_code),
        .line_end    (line_end),
        .bundle      (front_bundle),
        .bundle_push (front_push),
        .status      (front_stat)
    );

    // bundles that carry no token are never queued
    etl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_push),
        .wr_data   (front_bundle),
        .rd_en     (head_pop),
        .rd_data   (head_bundle),
        .not_empty (head_valid),
        .is_full   (full),
        .fill      (q_fill)
    );

    // back: walks the head bundle one token per result transaction
    etl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_bundle),
        .head_valid (head_valid),
        .take       (out_take),
        .head_pop   (head_pop),
        .tok        (out_tok)
    );

    assign empty        = !head_valid;
    assign token_kind   = out_tok.kind;
    assign start_pos    = out_tok.start;
    assign token_len    = out_tok.len;
    assign last_of_line = out_tok.last;

    // a queued bundle always carries at least one token
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        front_push |-> (|front_bundle.valid))
        else $error("empty bundle queued");

    // while the rest of a line is dropped nothing is held and nothing is queued
    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        front_stat.discarding |-> (front_stat.pend_idle && !front_push))
        else $error("activity while dropping a line");

    // queue fill never passes its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_fill <= CW'(QUEUE_DEPTH))
        else $error("queue overfilled");

    // a bundle leaves the queue only on a result transaction
    a_pop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> out_take)
        else $error("bundle dropped without transaction");

    // an end-of-line token closes its line and has no length
    a_eol_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind == etl_pkg::KIND_EOL) |-> (last_of_line && token_len == 12'd0))
        else $error("malformed end-of-line token");

endmodule

`default_nettype wire

>>> tb/token_stream_checker.sv
module token_stream_checker
    import etl_pkg::*;
#(
    parameter int LINE_MAX = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  char_code,
    input  logic        line_end,
    input  logic        empty,
    input  logic        pop,
    input  logic [4:0]  token_kind,
    input  logic [11:0] start_pos,
    input  logic [11:0] token_len,
    input  logic        last_of_line,
    output int          outstanding,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [11:0] POS_LIMIT = (LINE_MAX - 1 > 4095) ? 12'd4095 : 12'(LINE_MAX - 1);

    token_t      expected_tokens[$];
    pend_t       held       = PEND_NONE;
    logic [11:0] held_start = '0;
    logic [11:0] held_len   = '0;
    logic [11:0] line_pos   = '0;
    logic        dropping   = 1'b0;
    int          bad_count  = 0;

    assign mismatches = bad_count;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [11:0] next_pos(input logic [11:0] p);
        return (p < POS_LIMIT) ? p + 12'd1 : POS_LIMIT;
    endfunction

    // two-character operator formed by a held char and the new one
    function automatic kind_t paired_kind(input pend_t h, input logic [7:0] c);
        if (c == CH_EQ && h == PEND_EQ)   return KIND_EQ;
        if (c == CH_EQ && h == PEND_BANG) return KIND_NEQ;
        if (c == CH_EQ && h == PEND_LT)   return KIND_LE;
        if (c == CH_EQ && h == PEND_GT)   return KIND_GE;
        if (c == CH_AMP && h == PEND_AMP) return KIND_AND;
        if (c == CH_BAR && h == PEND_BAR) return KIND_OR;
        return KIND_ERR;
    endfunction

    task automatic expect_token(input kind_t k, input logic [11:0] s, input logic [11:0] n,
                                input logic last);
        token_t t;
        t.kind  = k;
        t.start = s;
        t.len   = n;
        t.last  = last;
        expected_tokens = {expected_tokens, t};
    endtask

    task automatic hold(input pend_t cls, input logic [11:0] p);
        held       = cls;
        held_start = p;
        held_len   = 12'd1;
    endtask

    // emit whatever is held as a token on its own
    task automatic flush_held(output logic err);
        pend_t cls;
        cls  = held;
        held = PEND_NONE;
        err  = 1'b0;
        case (cls)
            PEND_NONE:  ;
            PEND_IDENT: expect_token(KIND_IDENT, held_start, held_len, 1'b0);
            PEND_INT:   expect_token(KIND_INT, held_start, held_len, 1'b0);
            PEND_EQ:    expect_token(KIND_ASSIGN, held_start, 12'd1, 1'b0);
            PEND_LT:    expect_token(KIND_LT, held_start, 12'd1, 1'b0);
            PEND_GT:    expect_token(KIND_GT, held_start, 12'd1, 1'b0);
            default:
            begin
                expect_token(KIND_ERR, held_start, 12'd1, 1'b1);
                err = 1'b1;
            end
        endcase
    endtask

    // byte seen with nothing held
    task automatic open_byte(input logic [7:0] c, input logic [11:0] p, output logic err);
        err = 1'b0;
        if (is_alpha(c))
            hold(PEND_IDENT, p);
        else if (is_num(c))
            hold(PEND_INT, p);
        else if (!is_blank(c))
        begin
            case (c)
                CH_EQ:     hold(PEND_EQ, p);
                CH_BANG:   hold(PEND_BANG, p);
                CH_LT:     hold(PEND_LT, p);
                CH_GT:     hold(PEND_GT, p);
                CH_AMP:    hold(PEND_AMP, p);
                CH_BAR:    hold(PEND_BAR, p);
                CH_PLUS:   expect_token(KIND_ADD, p, 12'd1, 1'b0);
                CH_MINUS:  expect_token(KIND_SUB, p, 12'd1, 1'b0);
                CH_STAR:   expect_token(KIND_MUL, p, 12'd1, 1'b0);
                CH_SLASH:  expect_token(KIND_DIV, p, 12'd1, 1'b0);
                CH_LPAREN: expect_token(KIND_LPAREN, p, 12'd1, 1'b0);
                CH_RPAREN: expect_token(KIND_RPAREN, p, 12'd1, 1'b0);
                default:
                begin
                    expect_token(KIND_ERR, p, 12'd1, 1'b1);
                    err = 1'b1;
                end
            endcase
        end
    endtask

    // tokens caused by one accepted byte
    task automatic lex_byte(input logic [7:0] c, input logic eol);
        logic [11:0] p;
        logic        err;
        logic        taken;
        kind_t       k;
        p     = line_pos;
        err   = 1'b0;
        taken = 1'b0;
        if (dropping)
        begin
            if (eol)
            begin
                dropping = 1'b0;
                line_pos = '0;
            end
            else
                line_pos = next_pos(p);
        end
        else
        begin
            if (held == PEND_IDENT || held == PEND_INT)
            begin
                if (is_num(c) || (held == PEND_IDENT && is_alpha(c)))
                begin
                    if (held_len != LEN_CAP)
                        held_len = held_len + 12'd1;
                    taken = 1'b1;
                end
                else
                    flush_held(err);
            end
            else if (held != PEND_NONE)
            begin
                k = paired_kind(held, c);
                if (k != KIND_ERR)
                begin
                    expect_token(k, held_start, 12'd2, 1'b0);
                    held  = PEND_NONE;
                    taken = 1'b1;
                end
                else
                    flush_held(err);
            end
            if (!err && !taken)
                open_byte(c, p, err);
            if (!err && eol)
            begin
                flush_held(err);
                if (!err)
                    expect_token(KIND_EOL, next_pos(p), 12'd0, 1'b1);
            end
            if (err)
            begin
                held     = PEND_NONE;
                dropping = !eol;
            end
            if (eol)
            begin
                held       = PEND_NONE;
                held_start = '0;
                held_len   = '0;
                line_pos   = '0;
            end
            else
                line_pos = next_pos(p);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        token_t want;
        if (!rst_n)
        begin
            expected_tokens.delete();
            held        = PEND_NONE;
            held_start  = '0;
            held_len    = '0;
            line_pos    = '0;
            dropping    = 1'b0;
            outstanding <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_tokens.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: token with none expected: kind=%0d start=%0d len=%0d last=%0b",
                                 $time, token_kind, start_pos, token_len, last_of_line);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_kind !== want.kind || start_pos !== want.start ||
                        token_len !== want.len || last_of_line !== want.last)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display("%0t: token mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                     $time, want.kind, want.start, want.len, want.last,
                                     token_kind, start_pos, token_len, last_of_line);
                    end
                end
            end
            if (push && !full)
                lex_byte(char_code, line_end);
            outstanding <= expected_tokens.size();
        end
    end

endmodule

>>> tb/tb_expression_token_lexer.sv
module tb_expression_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    import etl_pkg::*;

    // cycles with no transaction on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // length of the forced receiver hold-off
    localparam int HOLD_CYCLES = 64;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  char_code;
    logic        line_end;
    logic        empty;
    logic        pop;
    logic [4:0]  token_kind;
    logic [11:0] start_pos;
    logic [11:0] token_len;
    logic        last_of_line;

    int          outstanding;
    int          mismatches;

    // bytes of the line being built, sent with line_end on the last one
    logic [7:0]  line_bytes[$];
    int          byte_total   = 0;
    // no idling on either side while set
    bit          steady       = 1'b0;
    // receiver hold-off requests, served in the receiver's own process
    int          stall_asked  = 0;
    int          stall_served = 0;

    expression_token_lexer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .line_end     (line_end),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .start_pos    (start_pos),
        .token_len    (token_len),
        .last_of_line (last_of_line)
    );

    // watches both channels, predicts tokens and compares them
    token_stream_checker token_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .line_end     (line_end),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .start_pos    (start_pos),
        .token_len    (token_len),
        .last_of_line (last_of_line),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one byte transaction, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] c, input logic eol);
        while (!steady && $urandom_range(0, 99) < 26)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        char_code <= c;
        line_end  <= eol;
        @(posedge clk);
        // full as it stood at the edge decides the transaction
        while (full)
            @(posedge clk);
        byte_total++;
    endtask

    task automatic send_line();
        foreach (line_bytes[i])
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    task automatic append_byte(input logic [7:0] c);
        line_bytes = {line_bytes, c};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endtask

    // letter or underscore, or also a digit when not the first char
    function automatic logic [7:0] word_char(input bit first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        if (r < 52)
            return 8'("A" + r - 26);
        if (r == 52)
            return CH_UNDER;
        return 8'("0" + r - 53);
    endfunction

    // space or one of the control chars 9..13
    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? CH_SPACE : 8'(8 + r);
    endfunction

    function automatic string op_lexeme(input int i);
        case (i)
            0:       return "=";
            1:       return "==";
            2:       return "!=";
            3:       return "<";
            4:       return "<=";
            5:       return ">";
            6:       return ">=";
            7:       return "&&";
            8:       return "||";
            9:       return "+";
            10:      return "-";
            11:      return "*";
            12:      return "/";
            13:      return "(";
            default: return ")";
        endcase
    endfunction

    // one well-formed lexeme or a blank, sometimes followed by a separator
    task automatic add_token();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick <= 2)
        begin
            n = $urandom_range(1, 6);
            append_byte(word_char(1'b1));
            repeat (n - 1) append_byte(word_char(1'b0));
        end
        else if (pick <= 4)
        begin
            n = $urandom_range(1, 5);
            repeat (n) append_byte(8'("0" + $urandom_range(0, 9)));
        end
        else if (pick <= 8)
            add_text(op_lexeme($urandom_range(0, 14)));
        else
            append_byte(blank_char());
        if ($urandom_range(0, 1) == 1)
            append_byte(blank_char());
    endtask

    // lone bang, ampersand or bar, or a byte outside the alphabet
    task automatic add_breaker();
        string odd;
        odd = "#$@;,.?~";
        case ($urandom_range(0, 3))
            0:
            begin
                append_byte(CH_BANG);
                append_byte(word_char(1'b1));
            end
            1:       append_byte(CH_AMP);
            2:       append_byte(CH_BAR);
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    append_byte(8'($urandom_range(128, 255)));
                else
                    append_byte(odd[$urandom_range(0, 7)]);
            end
        endcase
    endtask

    // mostly well-formed lines, some broken by an error, a few pure noise
    task automatic send_random_line();
        int shape;
        int n;
        shape = $urandom_range(0, 99);
        if (shape < 12)
        begin
            n = $urandom_range(1, 8);
            repeat (n) append_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) add_token();
            if (shape < 30)
                add_breaker();
            n = $urandom_range(0, 3);
            repeat (n) add_token();
        end
        send_line();
    endtask

    // token side: random pop, a long hold-off on request, none while steady
    initial
    begin : token_drain
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_asked)
            begin
                stall_served = stall_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 26)
                pop <= 1'b0;
            else
                pop <= 1'b1;
        end
    end

    // hang detection: cycles in a row without any transaction
    initial
    begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : byte_source
        int random_start;
        rst_n     = 1'b0;
        push      = 1'b0;
        char_code = '0;
        line_end  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // identifier with underscore and digits, ge, int, assign by a held equals
        add_text("_Z9>=0=x");
        send_line();
        // every two-char operator but ge, plus the single ones, gt flushed by plus
        add_text("==!=<=>+-*/()&&||");
        send_line();
        // lone ampersand, rest of the line dropped
        add_text("&a");
        send_line();
        // unknown low byte, the high byte after it is dropped with the line end
        append_byte(8'h00);
        add_text("b");
        append_byte(8'hFF);
        send_line();
        // held bar at line end gives an error and no end of line
        add_text("|");
        send_line();
        // lone bang, its follower swallowed
        add_text("!(");
        send_line();
        // blank line
        add_text(" ");
        send_line();
        // held less-than flushed at line end
        add_text("<");
        send_line();

        // random lines, with a stretch of no idling and one receiver hold-off
        random_start = byte_total;
        while (byte_total - random_start < 195)
        begin
            steady = (byte_total - random_start >= 80) && (byte_total - random_start < 150);
            if (stall_asked == 0 && byte_total - random_start >= 160)
                stall_asked++;
            send_random_line();
        end
        steady = 1'b0;

        push <= 1'b0;
        // let the last transaction reach the checker before trusting the count
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // catch any stray token after the last expected one
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
